/* rtl/sgi_pkg.sv */
// ============================================================================
// sgi_pkg
// Shared widths and stage records for the segment intersection pipeline.
// ============================================================================
package sgi_pkg;

    // Coordinate width of every endpoint and of the hit point.
    localparam int COORD_W = 16;
    // Endpoint differences and start offsets.
    localparam int DIFF_W  = COORD_W + 1;
    // One signed product of two differences.
    localparam int PROD_W  = 2 * DIFF_W;
    // Cross product: difference of two products.
    localparam int CROSS_W = PROD_W + 1;
    // Magnitude of a direction component.
    localparam int MAG_W   = COORD_W;
    // Magnitude of the cross product or of the t numerator.
    localparam int CMAG_W  = 2 * COORD_W + 1;
    // Split of the t numerator magnitude for the hit-point multiply.
    localparam int TLO_W   = COORD_W + 1;
    localparam int THI_W   = CMAG_W - TLO_W;
    // Dividend |dA| * |tn| and quotient widths.
    localparam int NUM_W   = MAG_W + CMAG_W;
    localparam int QUO_W   = COORD_W;

    // Item fields that ride along with the arithmetic to the last stage.
    typedef struct packed {
        logic                       hit;
        logic                       neg_x;
        logic                       neg_y;
        logic signed [COORD_W-1:0]  ax0;
        logic signed [COORD_W-1:0]  ay0;
    } t_side;

    // Result of the cross-product front end.
    typedef struct packed {
        t_side                      side;
        logic [CMAG_W-1:0]          c_mag;
        logic [CMAG_W-1:0]          tn_mag;
        logic [MAG_W-1:0]           dax_mag;
        logic [MAG_W-1:0]           day_mag;
    } t_geom;

    // Dividends and divisor handed to the divider.
    typedef struct packed {
        t_side                      side;
        logic [CMAG_W-1:0]          c_mag;
        logic [NUM_W-1:0]           num_x;
        logic [NUM_W-1:0]           num_y;
    } t_quot_req;

    // Quotient magnitudes out of the divider.
    typedef struct packed {
        t_side                      side;
        logic [QUO_W-1:0]           q_x;
        logic [QUO_W-1:0]           q_y;
    } t_quot;

endpackage

/* rtl/sgi_cross.sv */
// ============================================================================
// sgi_cross
// Four-stage front end: differences, products, cross products, range test.
// ============================================================================
module sgi_cross (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    input  logic [sgi_pkg::COORD_W-1:0]        i_ax0,
    input  logic [sgi_pkg::COORD_W-1:0]        i_ay0,
    input  logic [sgi_pkg::COORD_W-1:0]        i_ax1,
    input  logic [sgi_pkg::COORD_W-1:0]        i_ay1,
    input  logic [sgi_pkg::COORD_W-1:0]        i_bx0,
    input  logic [sgi_pkg::COORD_W-1:0]        i_by0,
    input  logic [sgi_pkg::COORD_W-1:0]        i_bx1,
    input  logic [sgi_pkg::COORD_W-1:0]        i_by1,
    output logic                               o_valid,
    output sgi_pkg::t_geom                     o_geom
);

    localparam int CW = sgi_pkg::COORD_W;
    localparam int DW = sgi_pkg::DIFF_W;
    localparam int PW = sgi_pkg::PROD_W;
    localparam int XW = sgi_pkg::CROSS_W;
    localparam int MW = sgi_pkg::MAG_W;
    localparam int KW = sgi_pkg::CMAG_W;

    function automatic logic [DW-1:0] diff(input logic [CW-1:0] a, input logic [CW-1:0] b);
        return {a[CW-1], a} - {b[CW-1], b};
    endfunction

    function automatic logic [MW-1:0] mag_d(input logic [DW-1:0] v);
        logic [DW-1:0] t;
        t = v[DW-1] ? (~v + 1'b1) : v;
        return t[MW-1:0];
    endfunction

    function automatic logic [KW-1:0] mag_c(input logic [XW-1:0] v);
        logic [XW-1:0] t;
        t = v[XW-1] ? (~v + 1'b1) : v;
        return t[KW-1:0];
    endfunction

    // True when num / den lies in [0, 1]; den is known to be nonzero.
    function automatic logic in_unit(input logic signed [XW-1:0] num,
                                     input logic signed [XW-1:0] den);
        logic num_nonpos;
        num_nonpos = num[XW-1] || (num == '0);
        if (!den[XW-1]) begin
            return !num[XW-1] && (num <= den);
        end else begin
            return num_nonpos && (num >= den);
        end
    endfunction

    // Stage 1: differences.
    logic                  r_s1_v;
    logic signed [DW-1:0]  r_dax, r_day, r_dbx, r_dby, r_sx, r_sy;
    logic signed [CW-1:0]  r_s1_ax0, r_s1_ay0;

    // Stage 2: products and direction magnitudes.
    logic                  r_s2_v;
    logic signed [PW-1:0]  r_p_ax_by, r_p_ay_bx, r_p_sx_by, r_p_sy_bx, r_p_sx_ay, r_p_sy_ax;
    logic [MW-1:0]         r_s2_dax_mag, r_s2_day_mag;
    logic                  r_s2_sgn_x, r_s2_sgn_y;
    logic signed [CW-1:0]  r_s2_ax0, r_s2_ay0;

    // Stage 3: cross products.
    logic                  r_s3_v;
    logic signed [XW-1:0]  r_c, r_tn, r_un;
    logic [MW-1:0]         r_s3_dax_mag, r_s3_day_mag;
    logic                  r_s3_sgn_x, r_s3_sgn_y;
    logic signed [CW-1:0]  r_s3_ax0, r_s3_ay0;

    // Stage 4: range test and magnitudes.
    logic                  r_s4_v;
    sgi_pkg::t_geom        r_s4;
    sgi_pkg::t_geom        n_s4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
        end else begin
            r_s1_v <= i_valid;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
            r_s4_v <= r_s3_v;
        end
    end

    always_comb begin
        n_s4              = r_s4;
        n_s4.side.hit     = (r_c != '0) && in_unit(r_tn, r_c) && in_unit(r_un, r_c);
        n_s4.side.neg_x   = r_s3_sgn_x ^ r_tn[XW-1] ^ r_c[XW-1];
        n_s4.side.neg_y   = r_s3_sgn_y ^ r_tn[XW-1] ^ r_c[XW-1];
        n_s4.side.ax0     = r_s3_ax0;
        n_s4.side.ay0     = r_s3_ay0;
        n_s4.c_mag        = mag_c(r_c);
        n_s4.tn_mag       = mag_c(r_tn);
        n_s4.dax_mag      = r_s3_dax_mag;
        n_s4.day_mag      = r_s3_day_mag;
    end

    always_ff @(posedge i_clk) begin
        r_dax    <= diff(i_ax1, i_ax0);
        r_day    <= diff(i_ay1, i_ay0);
        r_dbx    <= diff(i_bx1, i_bx0);
        r_dby    <= diff(i_by1, i_by0);
        r_sx     <= diff(i_bx0, i_ax0);
        r_sy     <= diff(i_by0, i_ay0);
        r_s1_ax0 <= i_ax0;
        r_s1_ay0 <= i_ay0;

        r_p_ax_by    <= r_dax * r_dby;
        r_p_ay_bx    <= r_day * r_dbx;
        r_p_sx_by    <= r_sx * r_dby;
        r_p_sy_bx    <= r_sy * r_dbx;
        r_p_sx_ay    <= r_sx * r_day;
        r_p_sy_ax    <= r_sy * r_dax;
        r_s2_dax_mag <= mag_d(r_dax);
        r_s2_day_mag <= mag_d(r_day);
        r_s2_sgn_x   <= r_dax[DW-1];
        r_s2_sgn_y   <= r_day[DW-1];
        r_s2_ax0     <= r_s1_ax0;
        r_s2_ay0     <= r_s1_ay0;

        r_c          <= {r_p_ax_by[PW-1], r_p_ax_by} - {r_p_ay_bx[PW-1], r_p_ay_bx};
        r_tn         <= {r_p_sx_by[PW-1], r_p_sx_by} - {r_p_sy_bx[PW-1], r_p_sy_bx};
        r_un         <= {r_p_sx_ay[PW-1], r_p_sx_ay} - {r_p_sy_ax[PW-1], r_p_sy_ax};
        r_s3_dax_mag <= r_s2_dax_mag;
        r_s3_day_mag <= r_s2_day_mag;
        r_s3_sgn_x   <= r_s2_sgn_x;
        r_s3_sgn_y   <= r_s2_sgn_y;
        r_s3_ax0     <= r_s2_ax0;
        r_s3_ay0     <= r_s2_ay0;

        r_s4         <= n_s4;
    end

    assign o_valid = r_s4_v;
    assign o_geom  = r_s4;

endmodule

/* rtl/sgi_mul.sv */
// ============================================================================
// sgi_mul
// Two-stage multiply of |dA| by |tn| for both axes, split in two halves.
// ============================================================================
module sgi_mul (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  sgi_pkg::t_geom          i_geom,
    output logic                    o_valid,
    output sgi_pkg::t_quot_req      o_req
);

    localparam int MW = sgi_pkg::MAG_W;
    localparam int LW = sgi_pkg::TLO_W;
    localparam int HW = sgi_pkg::THI_W;
    localparam int KW = sgi_pkg::CMAG_W;
    localparam int NW = sgi_pkg::NUM_W;

    // Stage 5: partial products.
    logic                  r_s5_v;
    logic [MW+LW-1:0]      r_lo_x, r_lo_y;
    logic [MW+HW-1:0]      r_hi_x, r_hi_y;
    sgi_pkg::t_side        r_s5_side;
    logic [KW-1:0]         r_s5_c_mag;

    // Stage 6: full dividends.
    logic                  r_s6_v;
    sgi_pkg::t_quot_req    r_s6;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_v <= 1'b0;
            r_s6_v <= 1'b0;
        end else begin
            r_s5_v <= i_valid;
            r_s6_v <= r_s5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo_x     <= (MW+LW)'(i_geom.dax_mag) * (MW+LW)'(i_geom.tn_mag[LW-1:0]);
        r_lo_y     <= (MW+LW)'(i_geom.day_mag) * (MW+LW)'(i_geom.tn_mag[LW-1:0]);
        r_hi_x     <= (MW+HW)'(i_geom.dax_mag) * (MW+HW)'(i_geom.tn_mag[KW-1:LW]);
        r_hi_y     <= (MW+HW)'(i_geom.day_mag) * (MW+HW)'(i_geom.tn_mag[KW-1:LW]);
        r_s5_side  <= i_geom.side;
        r_s5_c_mag <= i_geom.c_mag;

        r_s6.num_x <= {r_hi_x, {LW{1'b0}}} + NW'(r_lo_x);
        r_s6.num_y <= {r_hi_y, {LW{1'b0}}} + NW'(r_lo_y);
        r_s6.side  <= r_s5_side;
        r_s6.c_mag <= r_s5_c_mag;
    end

    assign o_valid = r_s6_v;
    assign o_req   = r_s6;

endmodule

/* rtl/sgi_div.sv */
// ============================================================================
// sgi_div
// Pipelined restoring divider, one quotient bit per stage, both axes.
// ============================================================================
module sgi_div (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  sgi_pkg::t_quot_req      i_req,
    output logic                    o_valid,
    output sgi_pkg::t_quot          o_quot
);

    localparam int QW = sgi_pkg::QUO_W;
    localparam int KW = sgi_pkg::CMAG_W;
    localparam int NW = sgi_pkg::NUM_W;

    // One register set per quotient bit.
    logic                  r_v      [QW];
    logic [KW-1:0]         r_rem_x  [QW];
    logic [KW-1:0]         r_rem_y  [QW];
    logic [QW-1:0]         r_low_x  [QW];
    logic [QW-1:0]         r_low_y  [QW];
    logic [QW-1:0]         r_q_x    [QW];
    logic [QW-1:0]         r_q_y    [QW];
    logic [KW-1:0]         r_d      [QW];
    sgi_pkg::t_side        r_side   [QW];

    for (genvar k = 0; k < QW; k++) begin : g_step
        logic                  v_in;
        logic [KW-1:0]         rem_x_in, rem_y_in, d_in;
        logic [QW-1:0]         low_x_in, low_y_in, q_x_in, q_y_in;
        sgi_pkg::t_side        side_in;
        logic [KW:0]           trial_x, trial_y, sub_x, sub_y;
        logic                  ge_x, ge_y;

        if (k == 0) begin : g_first
            // The quotient is below 2^QW, so the top bits start below the divisor.
            assign v_in     = i_valid;
            assign rem_x_in = i_req.num_x[NW-1:QW];
            assign rem_y_in = i_req.num_y[NW-1:QW];
            assign low_x_in = i_req.num_x[QW-1:0];
            assign low_y_in = i_req.num_y[QW-1:0];
            assign q_x_in   = '0;
            assign q_y_in   = '0;
            assign d_in     = i_req.c_mag;
            assign side_in  = i_req.side;
        end else begin : g_next
            assign v_in     = r_v[k-1];
            assign rem_x_in = r_rem_x[k-1];
            assign rem_y_in = r_rem_y[k-1];
            assign low_x_in = r_low_x[k-1];
            assign low_y_in = r_low_y[k-1];
            assign q_x_in   = r_q_x[k-1];
            assign q_y_in   = r_q_y[k-1];
            assign d_in     = r_d[k-1];
            assign side_in  = r_side[k-1];
        end

        always_comb begin
            trial_x = {rem_x_in, low_x_in[QW-1]};
            trial_y = {rem_y_in, low_y_in[QW-1]};
            sub_x   = trial_x - {1'b0, d_in};
            sub_y   = trial_y - {1'b0, d_in};
            ge_x    = trial_x >= {1'b0, d_in};
            ge_y    = trial_y >= {1'b0, d_in};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else begin
                r_v[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem_x[k] <= ge_x ? sub_x[KW-1:0] : trial_x[KW-1:0];
            r_rem_y[k] <= ge_y ? sub_y[KW-1:0] : trial_y[KW-1:0];
            r_low_x[k] <= {low_x_in[QW-2:0], 1'b0};
            r_low_y[k] <= {low_y_in[QW-2:0], 1'b0};
            r_q_x[k]   <= {q_x_in[QW-2:0], ge_x};
            r_q_y[k]   <= {q_y_in[QW-2:0], ge_y};
            r_d[k]     <= d_in;
            r_side[k]  <= side_in;
        end
    end

    assign o_valid     = r_v[QW-1];
    assign o_quot.side = r_side[QW-1];
    assign o_quot.q_x  = r_q_x[QW-1];
    assign o_quot.q_y  = r_q_y[QW-1];

endmodule

/* rtl/segment_intersection.sv */
// ============================================================================
// segment_intersection
// Fully pipelined 2D line segment intersection test in signed Q12.4.
// ============================================================================
// How to use this block:
// An item is two segments, A and B, given as four signed 16-bit endpoints.
// The item is taken at a rising clock edge where start is high and busy is
// low. The pipeline never stalls, so busy stays low and a new item can be
// taken at every clock edge: the throughput is one item per cycle.
// Each item gives exactly one result. The result shows up on o_crossed,
// o_hit_x and o_hit_y for exactly one cycle, marked by o_done high, and is
// taken at the clock edge that ends that cycle. Between the edge that took
// the item and the strobe lie the cross-product front end (four stages),
// the split hit-point multiplier (two stages), the divider (one stage for
// each of the 16 quotient bits) and the output register.
// The receiver cannot hold results off; results are never stalled.
// A synchronous active-low reset clears every valid bit, so no result is
// produced for anything in flight when reset is applied.
// o_crossed is 1 when the segments meet, endpoints included. Parallel or
// degenerate segments, and segments that miss, give o_crossed 0 and a point
// of (0, 0). The hit point is rounded toward zero along segment A.
// ============================================================================
module segment_intersection (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic signed [sgi_pkg::COORD_W-1:0] i_seg_a_start_x,
    input  logic signed [sgi_pkg::COORD_W-1:0] i_seg_a_start_y,
    input  logic signed [sgi_pkg::COORD_W-1:0] i_seg_a_end_x,
    input  logic signed [sgi_pkg::COORD_W-1:0] i_seg_a_end_y,
    input  logic signed [sgi_pkg::COORD_W-1:0] i_seg_b_start_x,
    input  logic signed [sgi_pkg::COORD_W-1:0] i_seg_b_start_y,
    input  logic signed [sgi_pkg::COORD_W-1:0] i_seg_b_end_x,
    input  logic signed [sgi_pkg::COORD_W-1:0] i_seg_b_end_y,
    output logic                             o_done,
    output logic                             o_crossed,
    output logic signed [sgi_pkg::COORD_W-1:0] o_hit_x,
    output logic signed [sgi_pkg::COORD_W-1:0] o_hit_y
);

    localparam int CW = sgi_pkg::COORD_W;

    logic                   geom_v;
    sgi_pkg::t_geom         geom;
    logic                   req_v;
    sgi_pkg::t_quot_req     req;
    logic                   quot_v;
    sgi_pkg::t_quot         quot;

    logic                   r_done;
    logic                   r_crossed;
    logic [CW-1:0]          r_hit_x, r_hit_y;
    logic [CW-1:0]          n_hit_x, n_hit_y;

    // Every stage accepts a new item each cycle, so the block is never busy.
    assign busy = 1'b0;

    // Differences, cross products and the [0, 1] range test for t and u.
    sgi_cross u_cross (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start),
        .i_ax0   (i_seg_a_start_x),
        .i_ay0   (i_seg_a_start_y),
        .i_ax1   (i_seg_a_end_x),
        .i_ay1   (i_seg_a_end_y),
        .i_bx0   (i_seg_b_start_x),
        .i_by0   (i_seg_b_start_y),
        .i_bx1   (i_seg_b_end_x),
        .i_by1   (i_seg_b_end_y),
        .o_valid (geom_v),
        .o_geom  (geom)
    );

    // Dividend |dA| * |tn| for each axis.
    sgi_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (geom_v),
        .i_geom  (geom),
        .o_valid (req_v),
        .o_req   (req)
    );

    // Quotient magnitudes |dA * tn| / |c|, which truncate toward zero.
    sgi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (req_v),
        .i_req   (req),
        .o_valid (quot_v),
        .o_quot  (quot)
    );

    // Apply the quotient sign and offset by the start of segment A. On a hit
    // the point lies on segment A, so the sum fits the coordinate width.
    always_comb begin
        n_hit_x = quot.side.neg_x ? (quot.side.ax0 - quot.q_x) : (quot.side.ax0 + quot.q_x);
        n_hit_y = quot.side.neg_y ? (quot.side.ay0 - quot.q_y) : (quot.side.ay0 + quot.q_y);
        if (!quot.side.hit) begin
            n_hit_x = '0;
            n_hit_y = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= quot_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_crossed <= quot.side.hit;
        r_hit_x   <= n_hit_x;
        r_hit_y   <= n_hit_y;
    end

    assign o_done    = r_done;
    assign o_crossed = r_crossed;
    assign o_hit_x   = r_hit_x;
    assign o_hit_y   = r_hit_y;

endmodule
